@@ rtl/mlbd_pkg.sv @@
`default_nettype none
package mlbd_pkg;

	// Fixed field and counter widths
	localparam int CNT_W    = 13;  // size registers and pixel counters
	localparam int SAMPLE_W = 16;  // one height sample
	localparam int SUM_W    = 17;  // horizontal pair sum
	localparam int ACC_W    = 18;  // full 2x2 block sum

	// Rounding bias of the 2x2 mean, added before the divide by four
	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(2);

	// Configuration register indexes
	localparam int REG_IDX_W = 1;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_SRC_WIDTH  = 1'b0;
	localparam reg_idx_t REG_SRC_HEIGHT = 1'b1;

	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [SUM_W-1:0]    pair_sum_t;
	typedef logic [ACC_W-1:0]    block_sum_t;

endpackage
`default_nettype wire

@@ rtl/mlbd_line_buf.sv @@
`default_nettype none
module mlbd_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  wire logic                clk,
	input  wire logic                wr_en,
	input  wire logic [AW-1:0]       wr_addr,
	input  wire mlbd_pkg::pair_sum_t wr_data,
	input  wire logic                rd_en,
	input  wire logic [AW-1:0]       rd_addr,
	output mlbd_pkg::pair_sum_t      rd_data
);

	mlbd_pkg::pair_sum_t mem [DEPTH];
	mlbd_pkg::pair_sum_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Hold the read data until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

@@ rtl/mip_level_box_downsampler.sv @@
`default_nettype none
// Mip level 2x2 box downsampler.
// Feed the height samples of one source level in raster order on the input
// channel (sample, in_valid, in_ready). Each 2x2 source block yields one item
// on the output channel (out_sample, last_of_level, out_valid, out_ready):
// the rounded mean (sum + 2) / 4. The output level is floor(W/2) by
// floor(H/2), at least 1 by 1; an odd trailing column or row is consumed and
// dropped, and a size of one reuses its single pixel for both taps.
// last_of_level marks the final output item of the level; the pixel counters
// wrap after the last input sample, so the next level may follow at once.
// Program src_width and src_height through cfg_we/cfg_index/cfg_data while
// the block is idle. A size of zero acts as one, a size above MAX_WIDTH or
// MAX_HEIGHT acts as that maximum.
//
// Throughput is one input item per clock while in_ready is high. Once the
// last sample of a block is accepted, stage 1 holds its pair sum and the
// line buffer read port registers the stored pair; the block sum then
// loads the output register. When the receiver stalls, the output register
// and the stage behind it fill, then in_ready drops. Reset clears the
// counters, sets both sizes to one and empties the pipeline; the line
// buffer needs no clearing, since each even row writes it before a read.
module mip_level_box_downsampler #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire mlbd_pkg::reg_idx_t     cfg_index,
	input  wire mlbd_pkg::cnt_t         cfg_data,
	// input channel
	input  wire mlbd_pkg::sample_t      sample,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	// output channel
	output mlbd_pkg::sample_t           out_sample,
	output logic                        last_of_level,
	output logic                        out_valid,
	input  wire logic                   out_ready
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int HALF_W     = mlbd_pkg::CNT_W - 1;

	// Configuration registers
	mlbd_pkg::cnt_t src_width_q;
	mlbd_pkg::cnt_t src_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= mlbd_pkg::CNT_W'(1);
			src_height_q <= mlbd_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				mlbd_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				mlbd_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes: zero acts as one, oversize clamps to the maximum
	mlbd_pkg::cnt_t w, h, nw, nh;

	always_comb begin
		if (src_width_q == '0) begin
			w = mlbd_pkg::CNT_W'(1);
		end else if (src_width_q > MAX_WIDTH) begin
			w = mlbd_pkg::CNT_W'(MAX_WIDTH);
		end else begin
			w = src_width_q;
		end
		if (src_height_q == '0) begin
			h = mlbd_pkg::CNT_W'(1);
		end else if (src_height_q > MAX_HEIGHT) begin
			h = mlbd_pkg::CNT_W'(MAX_HEIGHT);
		end else begin
			h = src_height_q;
		end
		nw = (w >= mlbd_pkg::CNT_W'(2)) ? (w >> 1) : mlbd_pkg::CNT_W'(1);
		nh = (h >= mlbd_pkg::CNT_W'(2)) ? (h >> 1) : mlbd_pkg::CNT_W'(1);
	end

	// Position counters and the even-column sample
	mlbd_pkg::cnt_t    col_q, row_q;
	mlbd_pkg::sample_t partial_q;

	logic                accept;
	logic [HALF_W-1:0]   x, y;
	mlbd_pkg::pair_sum_t pair;
	logic                have_pair, partial_load;
	logic                line_wr, line_rd, emit, use_line, last;
	mlbd_pkg::cnt_t      col_next, row_next;

	assign accept = in_valid && in_ready;

	always_comb begin
		x            = col_q[mlbd_pkg::CNT_W-1:1];
		y            = row_q[mlbd_pkg::CNT_W-1:1];
		pair         = '0;
		have_pair    = 1'b0;
		partial_load = 1'b0;
		line_wr      = 1'b0;
		line_rd      = 1'b0;
		emit         = 1'b0;
		use_line     = 1'b0;

		// Horizontal pair: a single column counts twice
		if (w == mlbd_pkg::CNT_W'(1)) begin
			x = '0;
			if (col_q == '0) begin
				pair      = {sample, 1'b0};
				have_pair = 1'b1;
			end
		end else if (col_q < {nw[HALF_W-1:0], 1'b0}) begin
			if (!col_q[0]) begin
				partial_load = 1'b1;
			end else begin
				pair      = {1'b0, partial_q} + {1'b0, sample};
				have_pair = 1'b1;
			end
		end

		// Vertical join: park even rows in the line buffer, finish on odd rows
		if (have_pair) begin
			if (h == mlbd_pkg::CNT_W'(1)) begin
				if (row_q == '0) begin
					emit = 1'b1;
				end
			end else if (row_q < {nh[HALF_W-1:0], 1'b0}) begin
				if (!row_q[0]) begin
					line_wr = 1'b1;
				end else begin
					line_rd  = 1'b1;
					emit     = 1'b1;
					use_line = 1'b1;
				end
			end
		end

		last = (x == HALF_W'(nw - mlbd_pkg::CNT_W'(1)))
			&& (y == HALF_W'(nh - mlbd_pkg::CNT_W'(1)));

		// Advance the raster position, wrap at the end of a row and the level
		if (col_q >= w - mlbd_pkg::CNT_W'(1)) begin
			col_next = '0;
			if (row_q >= h - mlbd_pkg::CNT_W'(1)) begin
				row_next = '0;
			end else begin
				row_next = row_q + mlbd_pkg::CNT_W'(1);
			end
		end else begin
			col_next = col_q + mlbd_pkg::CNT_W'(1);
			row_next = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			partial_q <= '0;
		end else if (accept) begin
			col_q <= col_next;
			row_q <= row_next;
			if (partial_load) begin
				partial_q <= sample;
			end
		end
	end

	// Line buffer of even-row pair sums
	logic [LINE_AW-1:0]  line_addr;
	mlbd_pkg::pair_sum_t line_rd_data;

	assign line_addr = LINE_AW'(x);

	mlbd_line_buf #(
		.DEPTH (LINE_DEPTH),
		.AW    (LINE_AW)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (accept && line_wr),
		.wr_addr (line_addr),
		.wr_data (pair),
		.rd_en   (accept && line_rd),
		.rd_addr (line_addr),
		.rd_data (line_rd_data)
	);

	// Stage 1: hold the pair sum while the line buffer read completes
	logic                v_s1;
	mlbd_pkg::pair_sum_t pair_s1;
	logic                use_line_s1;
	logic                last_s1;
	logic                out_load;

	assign out_load = !out_valid || out_ready;
	assign in_ready = !v_s1 || out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= emit;
		end else if (out_load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1     <= pair;
			use_line_s1 <= use_line;
			last_s1     <= last;
		end
	end

	// Block sum and rounded mean
	mlbd_pkg::pair_sum_t  other_pair;
	mlbd_pkg::block_sum_t block_sum;

	assign other_pair = use_line_s1 ? line_rd_data : pair_s1;
	assign block_sum  = {1'b0, other_pair} + {1'b0, pair_s1} + mlbd_pkg::ROUND_BIAS;

	// Output register
	logic              out_valid_q;
	mlbd_pkg::sample_t out_sample_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && v_s1) begin
			out_sample_q <= block_sum[mlbd_pkg::ACC_W-1:2];
			last_q       <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_sample    = out_sample_q;
	assign last_of_level = last_q;

	// Assertions
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (col_q == '0) || (col_q == $past(col_q) + mlbd_pkg::CNT_W'(1)))
		else $error("column counter neither advanced by one nor wrapped");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_load) |=> (v_s1 && $stable(pair_s1) && $stable(last_s1)))
		else $error("stalled stage 1 item lost or changed");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_load) |=> out_valid)
		else $error("stage 1 item did not reach the output register");

endmodule
`default_nettype wire
